// File: rtl/core/voice_stealing_allocator_defines.svh
// Assertion macros used by the checker of the voice allocator.
// Include by bare file name; needs nothing else.
`ifndef VOICE_STEALING_ALLOCATOR_DEFINES_SVH
`define VOICE_STEALING_ALLOCATOR_DEFINES_SVH

// Check a property while reset is low.
`define VSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define VSA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/vsa_pkg.sv
// Types and constants of the voice allocator.
// Used by the voice table, the top level and the testbench; depends on nothing.
package vsa_pkg;

   localparam int OWNER_W = 16;
   localparam int SUB_W   = 4;
   localparam int NOW_W   = 30;
   localparam int LEN_W   = 24;
   localparam int END_W   = 31;

   localparam logic [1:0] REQ_START    = 2'd0;
   localparam logic [1:0] REQ_STOP     = 2'd1;
   localparam logic [1:0] REQ_STOP_ALL = 2'd2;

   localparam logic [SUB_W-1:0] SUB_NONE = 4'h0;
   localparam logic [SUB_W-1:0] SUB_ANY  = 4'hF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } vsa_state_type;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [SUB_W-1:0]   sub;
      logic [END_W-1:0]   end_time;
      logic               active;
   } vsa_entry_type;

   typedef struct packed {
      logic          wr_en;
      logic          clear_all;
      vsa_entry_type data;
   } vsa_tbl_cmd_type;

endpackage

// File: rtl/core/vsa_if.sv
// Request and response channel interfaces of the voice allocator.
// Depends on nothing; used by the top level.
interface vsa_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [15:0]       entity;
   logic signed [3:0] subchannel;
   logic [29:0]       now;
   logic [23:0]       sound_length;
   logic              playable;

   modport source (output valid, req_type, entity, subchannel, now, sound_length, playable,
                    input ready);
   modport sink (input valid, req_type, entity, subchannel, now, sound_length, playable,
                 output ready);
endinterface

interface vsa_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [2:0] voice;
   logic       started;

   modport source (output valid, found, voice, started, input ready);
   modport sink (input valid, found, voice, started, output ready);
endinterface

// File: rtl/core/vsa_table.sv
// Voice table: one synchronous memory of voice entries, with a registered read.
// Per-entry valid bits make cleared entries read as zero. Depends on vsa_pkg.
module vsa_table import vsa_pkg::*; #(
   parameter int VOICES = 8,
   parameter int IDX_W  = 3
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output vsa_entry_type   rd_entry,
   input  vsa_tbl_cmd_type cmd,
   input  logic [IDX_W-1:0] wr_addr
);

   vsa_entry_type     mem [VOICES];
   vsa_entry_type     rd_data_ff;
   logic              rd_ok_ff;
   logic [VOICES-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= cmd.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_ok_ff   <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // a never-written or cleared entry reads as all zero
   assign rd_entry = rd_ok_ff ? rd_data_ff : '0;

endmodule

// File: rtl/core/voice_stealing_allocator.sv
// Top level of the voice allocator: request decode, voice scan and response register.
// Depends on vsa_pkg, vsa_req_if, vsa_rsp_if and vsa_table.
//
// Usage:
//   req_ch carries start, stop and stop-all requests; one is taken at a time,
//   on a transfer while valid and ready are both high. rsp_ch returns exactly
//   one response (found, voice, started) for every request, in order.
//   csr_wr_en / csr_wr_data write the protected entity; write it only while idle.
// Sequence:
//   Start and stop read one voice a cycle from the table memory and stop at the
//   first match, then load the response register; the next request is taken
//   only after the response is loaded. Stop-all and unknown requests skip the
//   scan and load their response straight from the done state.
// Reset:
//   Synchronous reset empties the table (valid bits cleared at once, no sweep),
//   clears the protected entity and drops any pending response.
// Stall:
//   A finished response waits in the output register while the next request is
//   taken; a request completing behind a stalled response holds until it leaves.
module voice_stealing_allocator import vsa_pkg::*; #(
   parameter int VOICES = 8
) (
   input  logic        clock,
   input  logic        reset,
   vsa_req_if.sink     req_ch,
   vsa_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int IDX_W = $clog2(VOICES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

   vsa_state_type      state_ff, state_in;
   logic [OWNER_W-1:0] prot_ff;

   logic [1:0]         rq_type_ff, rq_type_in;
   logic [OWNER_W-1:0] rq_ent_ff, rq_ent_in;
   logic [SUB_W-1:0]   rq_sub_ff, rq_sub_in;
   logic [NOW_W-1:0]   rq_now_ff, rq_now_in;
   logic [LEN_W-1:0]   rq_len_ff, rq_len_in;
   logic               rq_play_ff, rq_play_in;

   logic [IDX_W-1:0]   iss_ff, iss_in;
   logic               iss_done_ff, iss_done_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;

   logic               have_ff, have_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic [END_W-1:0]   best_end_ff, best_end_in;

   logic               res_found_ff, res_found_in;
   logic [IDX_W-1:0]   res_pick_ff, res_pick_in;
   logic               res_started_ff, res_started_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [2:0]         rsp_voice_ff, rsp_voice_in;
   logic               rsp_started_ff, rsp_started_in;

   logic               tbl_rd_en;
   vsa_entry_type      ent;
   vsa_tbl_cmd_type    tbl_cmd;
   logic [IDX_W-1:0]   tbl_wr_addr;

   logic               req_xfer;
   logic               hit_start, hit_stop, skip, better, last;
   logic [END_W-1:0]   new_end;
   logic [IDX_W+2:0]   pick_ext;

   vsa_table #(.VOICES(VOICES), .IDX_W(IDX_W)) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (tbl_rd_en),
      .rd_addr  (iss_ff),
      .rd_entry (ent),
      .cmd      (tbl_cmd),
      .wr_addr  (tbl_wr_addr)
   );

   // take nothing while reset is held
   assign req_ch.ready   = (state_ff == ST_IDLE) && !reset;
   assign req_xfer       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.found   = rsp_found_ff;
   assign rsp_ch.voice   = rsp_voice_ff;
   assign rsp_ch.started = rsp_started_ff;

   // per-entry compare on the entry just read
   assign hit_start = (rq_sub_ff != SUB_NONE) && (ent.owner == rq_ent_ff)
                      && ((ent.sub == rq_sub_ff) || (rq_sub_ff == SUB_ANY));
   assign hit_stop  = (ent.owner == rq_ent_ff) && (ent.sub == rq_sub_ff);
   assign skip      = (ent.owner == prot_ff) && (rq_ent_ff != prot_ff) && ent.active;
   // end - now orders the same as end, since now is common to all voices
   assign better    = !skip && (!have_ff || (ent.end_time < best_end_ff));
   assign last      = (cmp_idx_ff == LAST_IDX);
   assign new_end   = rq_play_ff ? ({1'b0, rq_now_ff} + {7'b0, rq_len_ff}) : '0;
   assign pick_ext  = {3'b0, res_pick_ff};

   always_comb begin
      state_in       = state_ff;
      rq_type_in     = rq_type_ff;
      rq_ent_in      = rq_ent_ff;
      rq_sub_in      = rq_sub_ff;
      rq_now_in      = rq_now_ff;
      rq_len_in      = rq_len_ff;
      rq_play_in     = rq_play_ff;
      iss_in         = iss_ff;
      iss_done_in    = iss_done_ff;
      have_in        = have_ff;
      best_in        = best_ff;
      best_end_in    = best_end_ff;
      res_found_in   = res_found_ff;
      res_pick_in    = res_pick_ff;
      res_started_in = res_started_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_voice_in   = rsp_voice_ff;
      rsp_started_in = rsp_started_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      tbl_rd_en      = 1'b0;
      tbl_cmd        = '0;
      tbl_wr_addr    = cmp_idx_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = iss_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               rq_type_in     = req_ch.req_type;
               rq_ent_in      = req_ch.entity;
               rq_sub_in      = $unsigned(req_ch.subchannel);
               rq_now_in      = req_ch.now;
               rq_len_in      = req_ch.sound_length;
               rq_play_in     = req_ch.playable;
               iss_in         = '0;
               iss_done_in    = 1'b0;
               have_in        = 1'b0;
               res_found_in   = 1'b0;
               res_pick_in    = '0;
               res_started_in = 1'b0;
               if ((req_ch.req_type == REQ_START) || (req_ch.req_type == REQ_STOP)) begin
                  state_in = ST_SCAN;
               end else begin
                  tbl_cmd.clear_all = (req_ch.req_type == REQ_STOP_ALL);
                  state_in          = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            // issue one read a cycle until the last voice has been read
            if (!iss_done_ff) begin
               tbl_rd_en   = 1'b1;
               cmp_vld_in  = 1'b1;
               iss_in      = iss_ff + 1'b1;
               iss_done_in = (iss_ff == LAST_IDX);
            end
            if (cmp_vld_ff) begin
               if (rq_type_ff == REQ_START) begin
                  tbl_cmd.data.owner    = rq_ent_ff;
                  tbl_cmd.data.sub      = rq_sub_ff;
                  tbl_cmd.data.end_time = new_end;
                  tbl_cmd.data.active   = rq_play_ff;
                  if (hit_start) begin
                     tbl_cmd.wr_en  = 1'b1;
                     tbl_wr_addr    = cmp_idx_ff;
                     res_found_in   = 1'b1;
                     res_pick_in    = cmp_idx_ff;
                     res_started_in = rq_play_ff;
                     state_in       = ST_DONE;
                  end else if (last) begin
                     tbl_cmd.wr_en  = have_ff || better;
                     tbl_wr_addr    = better ? cmp_idx_ff : best_ff;
                     res_found_in   = have_ff || better;
                     res_pick_in    = (have_ff || better) ? tbl_wr_addr : '0;
                     res_started_in = (have_ff || better) && rq_play_ff;
                     state_in       = ST_DONE;
                  end else if (better) begin
                     have_in     = 1'b1;
                     best_in     = cmp_idx_ff;
                     best_end_in = ent.end_time;
                  end
               end else begin
                  // stop: free the voice, keep owner and subchannel
                  tbl_cmd.data.owner    = ent.owner;
                  tbl_cmd.data.sub      = ent.sub;
                  tbl_cmd.data.end_time = '0;
                  tbl_cmd.data.active   = 1'b0;
                  if (hit_stop) begin
                     tbl_cmd.wr_en = 1'b1;
                     tbl_wr_addr   = cmp_idx_ff;
                     res_found_in  = 1'b1;
                     res_pick_in   = cmp_idx_ff;
                     state_in      = ST_DONE;
                  end else if (last) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = res_found_ff;
               rsp_voice_in   = pick_ext[2:0];
               rsp_started_in = res_started_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         iss_done_ff  <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         iss_done_ff  <= iss_done_in;
         have_ff      <= have_in;
         if (csr_wr_en) begin
            prot_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rq_type_ff     <= rq_type_in;
      rq_ent_ff      <= rq_ent_in;
      rq_sub_ff      <= rq_sub_in;
      rq_now_ff      <= rq_now_in;
      rq_len_ff      <= rq_len_in;
      rq_play_ff     <= rq_play_in;
      iss_ff         <= iss_in;
      cmp_idx_ff     <= cmp_idx_in;
      best_ff        <= best_in;
      best_end_ff    <= best_end_in;
      res_found_ff   <= res_found_in;
      res_pick_ff    <= res_pick_in;
      res_started_ff <= res_started_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_voice_ff   <= rsp_voice_in;
      rsp_started_ff <= rsp_started_in;
   end

endmodule

// File: rtl/core/vsa_checker.sv
// Port-level checker of the voice allocator, bound to the top level.
// Depends on voice_stealing_allocator_defines.svh and the top level's ports.
`include "voice_stealing_allocator_defines.svh"

module vsa_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_found,
   input logic [2:0] rsp_voice,
   input logic       rsp_started
);

   `VSA_ASSERT_ALWAYS(a_reset_drops_rsp, clock, reset |=> !rsp_valid, "response valid after reset")
   `VSA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_found, rsp_voice, rsp_started}), "stalled response changed")
   `VSA_ASSERT(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while one is in work")
   `VSA_ASSERT(a_started_found, clock, reset, rsp_valid && rsp_started |-> rsp_found, "started without a voice")
   `VSA_ASSERT(a_miss_voice_zero, clock, reset, rsp_valid && !rsp_found |-> rsp_voice == 3'd0, "miss with nonzero voice")

endmodule

bind voice_stealing_allocator vsa_checker u_vsa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_found   (rsp_ch.found),
   .rsp_voice   (rsp_ch.voice),
   .rsp_started (rsp_ch.started)
);

// File: dv/voice_stealing_allocator_test.sv
// Self-checking testbench for voice_stealing_allocator: directed table, then random traffic.
// Depends on vsa_pkg, vsa_if.sv (vsa_req_if, vsa_rsp_if) and the allocator RTL.
module voice_stealing_allocator_test import vsa_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VOICES        = 8;
   localparam int PHASES        = 4;
   localparam int PHASE_ITEMS   = 345;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int DIRECTED_N    = 25;

   localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
   localparam bit [15:0]   ENT_MAX     = 16'hFFFF;
   localparam bit [29:0]   NOW_MAX     = 30'h3FFF_FFFF;
   localparam bit [23:0]   LEN_MAX     = 24'hFF_FFFF;
   localparam longint      LIFE_INIT   = 64'h7FFF_FFFF;

   typedef struct packed {
      bit [1:0]  kind;
      bit [15:0] entity;
      bit [3:0]  sub;
      bit [29:0] now;
      bit [23:0] length;
      bit        playable;
   } voice_req_type;

   typedef struct packed {
      bit       found;
      bit [2:0] voice;
      bit       started;
   } voice_rsp_type;

   typedef struct packed {
      voice_req_type rq;
      bit            typed;
      voice_rsp_type rsp;
   } directed_row_type;

   logic clock;
   logic reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   vsa_req_if req_ch ();
   vsa_rsp_if rsp_ch ();

   voice_stealing_allocator #(.VOICES(VOICES)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Mirror of the voice table and the protected entity register
   bit [15:0] owner_tbl  [VOICES];
   bit [3:0]  sub_tbl    [VOICES];
   bit [31:0] end_tbl    [VOICES];
   bit        active_tbl [VOICES];
   bit [15:0] protected_ent;

   voice_rsp_type alloc_results_q [$];

   bit [29:0] paint_time;
   bit        sender_gaps;
   bit        sink_stalls;
   int        stall_left;
   int        cycle_count;
   int        fail_count;
   int        compared_n;
   int        starts_n, stops_n, clears_n, unknown_n, refused_n, stop_hits_n;

   directed_row_type directed_rows [DIRECTED_N] = '{
      '{'{REQ_STOP,     16'd5,   4'd1,     30'd0,    24'd0,    1'b0}, 1'b1, '{1'b0, 3'd0, 1'b0}},
      '{'{REQ_START,    ENT_MAX, 4'd7,     NOW_MAX,  LEN_MAX,  1'b1}, 1'b1, '{1'b1, 3'd0, 1'b1}},
      '{'{REQ_START,    ENT_MAX, 4'd7,     30'd100,  24'd5,    1'b1}, 1'b0, '0},
      '{'{REQ_START,    ENT_MAX, SUB_ANY,  30'd200,  24'd10,   1'b0}, 1'b0, '0},
      '{'{REQ_STOP,     ENT_MAX, SUB_ANY,  30'd210,  24'd0,    1'b0}, 1'b0, '0},
      '{'{REQ_START,    16'd1,   SUB_NONE, 30'd300,  24'd50,   1'b1}, 1'b0, '0},
      '{'{REQ_START,    16'd1,   SUB_NONE, 30'd310,  24'd50,   1'b1}, 1'b0, '0},
      '{'{REQ_START,    16'd2,   4'd3,     30'd320,  24'd40,   1'b1}, 1'b0, '0},
      '{'{REQ_STOP,     16'd2,   4'd3,     30'd330,  24'd0,    1'b0}, 1'b0, '0},
      '{'{REQ_STOP,     16'd1,   SUB_ANY,  30'd340,  24'd0,    1'b0}, 1'b0, '0},
      '{'{REQ_UNKNOWN,  ENT_MAX, SUB_ANY,  NOW_MAX,  LEN_MAX,  1'b1}, 1'b1, '{1'b0, 3'd0, 1'b0}},
      '{'{REQ_STOP_ALL, 16'd0,   SUB_NONE, 30'd0,    24'd0,    1'b0}, 1'b1, '{1'b0, 3'd0, 1'b0}},
      '{'{REQ_START,    16'd0,   SUB_NONE, 30'd1000, 24'd1000, 1'b1}, 1'b0, '0},
      '{'{REQ_START,    16'd0,   SUB_NONE, 30'd1000, 24'd1000, 1'b1}, 1'b0, '0},
      '{'{REQ_START,    16'd0,   SUB_NONE, 30'd1000, 24'd1000, 1'b1}, 1'b0, '0},
      '{'{REQ_START,    16'd0,   SUB_NONE, 30'd1000, 24'd1000, 1'b1}, 1'b0, '0},
      '{'{REQ_START,    16'd0,   SUB_NONE, 30'd1000, 24'd1000, 1'b1}, 1'b0, '0},
      '{'{REQ_START,    16'd0,   SUB_NONE, 30'd1000, 24'd1000, 1'b1}, 1'b0, '0},
      '{'{REQ_START,    16'd0,   SUB_NONE, 30'd1000, 24'd1000, 1'b1}, 1'b0, '0},
      '{'{REQ_START,    16'd0,   SUB_NONE, 30'd1000, 24'd1000, 1'b1}, 1'b0, '0},
      // every voice now belongs to the protected entity and plays
      '{'{REQ_START,    16'd9,   4'd2,     30'd1200, 24'd10,   1'b1}, 1'b1, '{1'b0, 3'd0, 1'b0}},
      '{'{REQ_START,    16'd0,   4'd5,     30'd1500, 24'd10,   1'b0}, 1'b0, '0},
      '{'{REQ_START,    16'd9,   4'd2,     30'd1600, 24'd10,   1'b1}, 1'b0, '0},
      '{'{REQ_STOP,     16'd9,   4'd2,     30'd1700, 24'd0,    1'b0}, 1'b0, '0},
      '{'{REQ_STOP_ALL, ENT_MAX, SUB_ANY,  NOW_MAX,  LEN_MAX,  1'b1}, 1'b1, '{1'b0, 3'd0, 1'b0}}
   };

   always #2 clock = ~clock;

   function automatic voice_rsp_type apply_request(voice_req_type rq);
      voice_rsp_type rs;
      int            pick;
      bit            matched;
      longint        life;
      longint        left;
      rs      = '0;
      pick    = -1;
      matched = 1'b0;
      life    = LIFE_INIT;
      case (rq.kind)
         REQ_START: begin
            for (int i = 0; i < VOICES && !matched; i++) begin
               if (rq.sub != SUB_NONE && owner_tbl[i] == rq.entity &&
                   (sub_tbl[i] == rq.sub || rq.sub == SUB_ANY)) begin
                  pick    = i;
                  matched = 1'b1;
               end else if (!(owner_tbl[i] == protected_ent && rq.entity != protected_ent &&
                              active_tbl[i])) begin
                  left = longint'(end_tbl[i]) - longint'(rq.now);
                  if (left < life) begin
                     life = left;
                     pick = i;
                  end
               end
            end
            if (pick >= 0) begin
               owner_tbl[pick]  = rq.entity;
               sub_tbl[pick]    = rq.sub;
               active_tbl[pick] = rq.playable;
               end_tbl[pick]    = rq.playable ? 32'(rq.now) + 32'(rq.length) : 32'd0;
               rs = '{1'b1, 3'(pick), rq.playable};
            end
         end
         REQ_STOP: begin
            for (int i = 0; i < VOICES && !matched; i++) begin
               if (owner_tbl[i] == rq.entity && sub_tbl[i] == rq.sub) begin
                  end_tbl[i]    = 32'd0;
                  active_tbl[i] = 1'b0;
                  matched       = 1'b1;
                  rs            = '{1'b1, 3'(i), 1'b0};
               end
            end
         end
         REQ_STOP_ALL: begin
            for (int i = 0; i < VOICES; i++) begin
               owner_tbl[i]  = '0;
               sub_tbl[i]    = '0;
               end_tbl[i]    = '0;
               active_tbl[i] = 1'b0;
            end
         end
         default: ;
      endcase
      return rs;
   endfunction

   function automatic voice_req_type make_random_request();
      voice_req_type rq;
      int            roll;
      int            slot;
      roll = $urandom_range(0, 99);
      if (roll < 58)      rq.kind = REQ_START;
      else if (roll < 94) rq.kind = REQ_STOP;
      else if (roll < 97) rq.kind = REQ_STOP_ALL;
      else                rq.kind = REQ_UNKNOWN;
      // keep owners in a small pool so reuse, stops and guarding actually happen
      if ($urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 5))
            0: rq.entity = 16'd0;
            1: rq.entity = 16'd1;
            2: rq.entity = 16'd2;
            3: rq.entity = 16'd3;
            4: rq.entity = protected_ent;
            default: rq.entity = ENT_MAX;
         endcase
      end else begin
         rq.entity = 16'($urandom);
      end
      rq.sub = ($urandom_range(0, 8) == 8) ? SUB_ANY : 4'($urandom_range(0, 7));
      if (rq.kind == REQ_STOP && $urandom_range(0, 9) < 6) begin
         slot      = $urandom_range(0, VOICES - 1);
         rq.entity = owner_tbl[slot];
         rq.sub    = sub_tbl[slot];
      end
      if ($urandom_range(0, 99) < 3) paint_time = 30'($urandom);
      else                           paint_time = paint_time + 30'($urandom_range(0, 2000));
      rq.now      = paint_time;
      rq.length   = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
      rq.playable = ($urandom_range(0, 99) < 85);
      return rq;
   endfunction

   task automatic send_request(input voice_req_type rq, input bit typed,
                               input voice_rsp_type typed_rsp);
      voice_rsp_type rs;
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= rq.kind;
      req_ch.entity       <= rq.entity;
      req_ch.subchannel   <= rq.sub;
      req_ch.now          <= rq.now;
      req_ch.sound_length <= rq.length;
      req_ch.playable     <= rq.playable;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      rs = apply_request(rq);
      case (rq.kind)
         REQ_START: begin
            starts_n++;
            if (!rs.found) refused_n++;
         end
         REQ_STOP: begin
            stops_n++;
            if (rs.found) stop_hits_n++;
         end
         REQ_STOP_ALL: clears_n++;
         default: unknown_n++;
      endcase
      alloc_results_q.push_back(typed ? typed_rsp : rs);
   endtask

   task automatic hold_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
   endtask

   // Drop valid, then wait for every outstanding response plus the block's latency
   task automatic drain_responses();
      hold_sender(1);
      while (alloc_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_protected(input bit [15:0] value);
      @(negedge clock);
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= value;
      protected_ent  = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Response side: random stall bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 6);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      voice_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (alloc_results_q.size() == 0) begin
            $display("%0t: response with none outstanding: found=%0b voice=%0d started=%0b",
                     $time, rsp_ch.found, rsp_ch.voice, rsp_ch.started);
            fail_count++;
         end else begin
            want = alloc_results_q.pop_front();
            compared_n++;
            if (rsp_ch.found !== want.found) begin
               $display("%0t: found mismatch: expected %0b, actual %0b",
                        $time, want.found, rsp_ch.found);
               fail_count++;
            end
            if (rsp_ch.voice !== want.voice) begin
               $display("%0t: voice mismatch: expected %0d, actual %0d",
                        $time, want.voice, rsp_ch.voice);
               fail_count++;
            end
            if (rsp_ch.started !== want.started) begin
               $display("%0t: started mismatch: expected %0b, actual %0b",
                        $time, want.started, rsp_ch.started);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, alloc_results_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      voice_req_type rq;
      bit [15:0]     guard;
      clock               = 1'b0;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_START;
      req_ch.entity       = '0;
      req_ch.subchannel   = '0;
      req_ch.now          = '0;
      req_ch.sound_length = '0;
      req_ch.playable     = 1'b0;
      rsp_ch.ready        = 1'b0;
      stall_left          = 0;
      sender_gaps         = 1'b1;
      sink_stalls         = 1'b1;
      protected_ent       = '0;
      paint_time          = '0;
      for (int i = 0; i < VOICES; i++) begin
         owner_tbl[i]  = '0;
         sub_tbl[i]    = '0;
         end_tbl[i]    = '0;
         active_tbl[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_N; r++) begin
         if (sender_gaps && $urandom_range(0, 3) == 0) hold_sender($urandom_range(1, 7));
         send_request(directed_rows[r].rq, directed_rows[r].typed, directed_rows[r].rsp);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_responses();
         case (p)
            0: guard = ENT_MAX;
            1: guard = 16'd3;
            2: guard = 16'($urandom);
            default: guard = 16'd0;
         endcase
         write_protected(guard);
         if (p == PHASES - 1) begin
            sender_gaps = 1'b0;
            sink_stalls = 1'b0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 3) drain_responses();
            if (sender_gaps && $urandom_range(0, 3) == 0) hold_sender($urandom_range(1, 7));
            rq = make_random_request();
            send_request(rq, 1'b0, '0);
         end
      end

      drain_responses();
      $display("Covered %0d starts (%0d refused for lack of a free voice), %0d stops (%0d hits),",
               starts_n, refused_n, stops_n, stop_hits_n);
      $display("%0d clears, %0d unknown requests, %0d responses compared, four guard settings",
               clears_n, unknown_n, compared_n);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
